// ----- rtl/core/fqp_pkg.sv -----
package fqp_pkg;

  localparam int BUCKET_ID_BITS_DEF = 5;
  localparam int MAX_ATTEMPTS_DEF   = 4;
  localparam int PROB_FRAC_BITS_DEF = 16;

  localparam int CFG_DATA_W = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int SCORE_W    = 40;
  localparam int TIME_W     = 47;
  localparam int EXP_W      = 48;
  localparam int TRES_W     = 20;
  localparam int IN_W       = 176;
  localparam int PROD_W     = 33;
  localparam int WIDE_W     = 62;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROTECT_ON      = 3'd0,
    REG_CRITICAL_DELAY  = 3'd1,
    REG_CRITICAL_SCORE  = 3'd2,
    REG_MAX_SCORE       = 3'd3,
    REG_AGING_EXPONENT  = 3'd4,
    REG_TIME_RESOLUTION = 3'd5,
    REG_ATTEMPTS        = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic              protect_on;
    logic [31:0]       critical_delay_ns;
    logic [39:0]       critical_score;
    logic [39:0]       max_score;
    logic [4:0]        aging_exponent;
    logic [TRES_W-1:0] time_resolution;
    logic [2:0]        attempts;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_time;
    logic [31:0]       queue_delay_ns;
    logic [16:0]       mark_probability;
    logic [15:0]       packet_size;
    logic [31:0]       flow_hash;
    logic [31:0]       flow_tag;
  } item_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] level;
  } fifo_stat_t;

endpackage

// ----- rtl/core/flow_queue_protection_core.sv -----
// Each accepted word passes the bit-serial score divider in the front, then the back;
// the back probes up to attempts buckets, with attempts capped at MAX_ATTEMPTS, and
// skips the bucket work with protection off. The front takes no new word until its score
// is pushed; the back runs concurrently behind a two-entry queue.
// Reset: synchronous, active high; registers take their documented defaults and all
// buckets read as unclaimed with zero owner and zero expiry. No clearing pass.
module flow_queue_protection_core #(
  parameter int BUCKET_ID_BITS = fqp_pkg::BUCKET_ID_BITS_DEF,
  parameter int MAX_ATTEMPTS   = fqp_pkg::MAX_ATTEMPTS_DEF,
  parameter int PROB_FRAC_BITS = fqp_pkg::PROB_FRAC_BITS_DEF,
  parameter int OUT_W          = ((BUCKET_ID_BITS + 42 + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fqp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fqp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // flow_tag, flow_hash, packet_size, mark_probability, queue_delay_ns, now_time
  input  logic [fqp_pkg::IN_W-1:0]         s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // sanction, bucket_index, queuing_score, zero fill
  output logic [OUT_W-1:0]                 m_tdata
);
  import fqp_pkg::*;

  localparam int DIV_W = WIDE_W - PROB_FRAC_BITS;
  localparam int Q_W   = $bits(item_t) + DIV_W;

  cfg_t             cfg;
  item_t            in_item;
  item_t            f_item;
  item_t            b_item;
  logic [DIV_W-1:0] f_score;
  logic [DIV_W-1:0] b_score;
  logic             q_push;
  logic             q_pop;
  fifo_stat_t       q_stat;
  logic [Q_W-1:0]   q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protect_on        <= 1'b1;
      cfg.critical_delay_ns <= 32'd1000000;
      cfg.critical_score    <= 40'd4000000;
      cfg.max_score         <= 40'd5000000000;
      cfg.aging_exponent    <= 5'd19;
      cfg.time_resolution   <= TRES_W'(1);
      cfg.attempts          <= 3'd2;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PROTECT_ON:      cfg.protect_on        <= cfg_data[0];
        REG_CRITICAL_DELAY:  cfg.critical_delay_ns <= cfg_data[31:0];
        REG_CRITICAL_SCORE:  cfg.critical_score    <= cfg_data[39:0];
        REG_MAX_SCORE:       cfg.max_score         <= cfg_data[39:0];
        REG_AGING_EXPONENT:  cfg.aging_exponent    <= cfg_data[4:0];
        REG_TIME_RESOLUTION: cfg.time_resolution   <= cfg_data[TRES_W-1:0];
        REG_ATTEMPTS:        cfg.attempts          <= cfg_data[2:0];
        default:             cfg.protect_on        <= cfg.protect_on;
      endcase
    end
  end

  assign in_item.flow_tag         = s_tdata[31:0];
  assign in_item.flow_hash        = s_tdata[63:32];
  assign in_item.packet_size      = s_tdata[79:64];
  assign in_item.mark_probability = s_tdata[96:80];
  assign in_item.queue_delay_ns   = s_tdata[128:97];
  assign in_item.now_time         = s_tdata[175:129];

  fqp_front #(
    .PROB_FRAC_BITS (PROB_FRAC_BITS),
    .DIV_W          (DIV_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .q_full   (q_stat.full),
    .q_push   (q_push),
    .q_item   (f_item),
    .q_score  (f_score)
  );

  fqp_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  ({f_item, f_score}),
    .pop  (q_pop),
    .dout (q_dout),
    .stat (q_stat)
  );

  assign b_item  = q_dout[Q_W-1:DIV_W];
  assign b_score = q_dout[DIV_W-1:0];

  fqp_back #(
    .BUCKET_ID_BITS (BUCKET_ID_BITS),
    .MAX_ATTEMPTS   (MAX_ATTEMPTS),
    .DIV_W          (DIV_W),
    .OUT_W          (OUT_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_stat.empty),
    .q_pop    (q_pop),
    .q_item   (b_item),
    .q_score  (b_score),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTH
  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    q_stat.level <= 2'd2)
    else $error("queue level overflow");

  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[BUCKET_ID_BITS+1:1] <= (1 << BUCKET_ID_BITS))
    else $error("bucket index out of range");

  a_score_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[BUCKET_ID_BITS+41:BUCKET_ID_BITS+2] <= cfg.max_score)
    else $error("queuing score above cap");

  a_sanction_score: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> m_tdata[BUCKET_ID_BITS+41:BUCKET_ID_BITS+2] != 40'd0)
    else $error("sanction with zero score");
`endif

endmodule

// ----- rtl/core/fqp_ram.sv -----
module fqp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/fqp_fifo.sv -----
module fqp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   din,
  input  logic               pop,
  output logic [WIDTH-1:0]   dout,
  output fqp_pkg::fifo_stat_t stat
);
  import fqp_pkg::*;

  logic [WIDTH-1:0] mem0;
  logic [WIDTH-1:0] mem1;
  logic [1:0]       count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: begin
          count <= count + 2'd1;
        end
        2'b01: begin
          count <= count - 2'd1;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          mem0 <= din;
        end else begin
          mem1 <= din;
        end
      end
      2'b01: begin
        mem0 <= mem1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          mem0 <= din;
        end else begin
          mem0 <= mem1;
          mem1 <= din;
        end
      end
      default: begin
        mem0 <= mem0;
      end
    endcase
  end

  assign dout       = mem0;
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign stat.level = count;

endmodule

// ----- rtl/core/fqp_front.sv -----
module fqp_front #(
  parameter int PROB_FRAC_BITS = fqp_pkg::PROB_FRAC_BITS_DEF,
  parameter int DIV_W          = fqp_pkg::WIDE_W - PROB_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  fqp_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  fqp_pkg::item_t      in_item,
  input  logic                q_full,
  output logic                q_push,
  output fqp_pkg::item_t      q_item,
  output logic [DIV_W-1:0]    q_score
);
  import fqp_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_LOAD = 5'b00100,
    F_DIV  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t           state;
  item_t             item;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  dvd;
  logic [TRES_W-1:0] rem;
  logic [TRES_W-1:0] tres;
  logic [CNT_W-1:0]  cnt;
  logic [4:0]        lg;
  logic [4:0]        sh;
  logic [WIDE_W-1:0] wide;
  logic [TRES_W:0]   rem_sh;
  logic              qbit;

  always_comb begin
    lg = cfg.aging_exponent;
    if (lg < 5'd1) begin
      lg = 5'd1;
    end else if (lg > 5'd30) begin
      lg = 5'd30;
    end
    sh     = 5'd30 - lg;
    wide   = {{(WIDE_W-PROD_W){1'b0}}, prod} << sh;
    rem_sh = {rem, dvd[DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, tres});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            state <= F_MUL;
          end
        end
        F_MUL: begin
          state <= F_LOAD;
        end
        F_LOAD: begin
          state <= F_DIV;
        end
        F_DIV: begin
          if (cnt == CNT_W'(DIV_W - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        item <= in_item;
      end
      F_MUL: begin
        prod <= PROD_W'({16'd0, item.mark_probability} * {17'd0, item.packet_size});
      end
      F_LOAD: begin
        dvd  <= wide[WIDE_W-1:PROB_FRAC_BITS];
        rem  <= '0;
        cnt  <= '0;
        tres <= (cfg.time_resolution == '0) ? TRES_W'(1) : cfg.time_resolution;
      end
      F_DIV: begin
        rem <= qbit ? TRES_W'(rem_sh - {1'b0, tres}) : rem_sh[TRES_W-1:0];
        dvd <= {dvd[DIV_W-2:0], qbit};
        cnt <= cnt + CNT_W'(1);
      end
      default: begin
        item <= item;
      end
    endcase
  end

  assign in_ready = (state == F_IDLE);
  assign q_push   = (state == F_PUSH) && !q_full;
  assign q_item   = item;
  assign q_score  = dvd;

endmodule

// ----- rtl/core/fqp_back.sv -----
module fqp_back #(
  parameter int BUCKET_ID_BITS = fqp_pkg::BUCKET_ID_BITS_DEF,
  parameter int MAX_ATTEMPTS   = fqp_pkg::MAX_ATTEMPTS_DEF,
  parameter int DIV_W          = 46,
  parameter int OUT_W          = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  fqp_pkg::cfg_t      cfg,
  input  logic               q_empty,
  output logic               q_pop,
  input  fqp_pkg::item_t     q_item,
  input  logic [DIV_W-1:0]   q_score,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata
);
  import fqp_pkg::*;

  localparam int NBKT  = 1 << BUCKET_ID_BITS;
  localparam int AW    = BUCKET_ID_BITS + 1;
  localparam int RAM_W = 32 + EXP_W;
  localparam int SUM_W = ((EXP_W > DIV_W) ? EXP_W : DIV_W) + 1;
  localparam int N_W   = $clog2(MAX_ATTEMPTS + 1);
  localparam int P_W   = 72;

  typedef enum logic [14:0] {
    B_IDLE = 15'b000000000000001,
    B_PRD  = 15'b000000000000010,
    B_PCMP = 15'b000000000000100,
    B_FRD  = 15'b000000000001000,
    B_DIFF = 15'b000000000010000,
    B_SUM  = 15'b000000000100000,
    B_CAP  = 15'b000000001000000,
    B_M0   = 15'b000000010000000,
    B_M1   = 15'b000000100000000,
    B_M2   = 15'b000001000000000,
    B_M3   = 15'b000010000000000,
    B_CB1  = 15'b000100000000000,
    B_CB2  = 15'b001000000000000,
    B_CMP  = 15'b010000000000000,
    B_OUT  = 15'b100000000000000
  } bstate_t;

  bstate_t          state;
  item_t            item;
  logic [DIV_W-1:0] score;
  logic [NBKT:0]    valid;
  logic [31:0]      hash;
  logic [N_W-1:0]   n;
  logic [N_W-1:0]   j;
  logic [AW-1:0]    cur_b;
  logic [AW-1:0]    spare;
  logic [AW-1:0]    spare_n;
  logic [AW-1:0]    chosen;
  logic [EXP_W-1:0] diff;
  logic [SUM_W-1:0] sum;
  logic [39:0]      delta;
  logic [51:0]      p_lo;
  logic [51:0]      p_hi;
  logic [51:0]      c_lo;
  logic [51:0]      c_hi;
  logic [P_W-1:0]   pw;
  logic [P_W-1:0]   cw;
  logic             sanc;
  logic             off;

  logic             ram_we;
  logic [AW-1:0]    ram_raddr;
  logic [RAM_W-1:0] ram_wdata;
  logic [RAM_W-1:0] ram_rdata;
  logic [31:0]      rd_owner;
  logic [EXP_W-1:0] rd_exp;
  logic [EXP_W-1:0] now_x;
  logic             hit;
  logic [31:0]      mul_a;
  logic [19:0]      mul_b;
  logic [51:0]      mul_p;
  logic             load_out;
  logic [N_W-1:0]   att;

  fqp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NBKT + 1)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (chosen),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    now_x    = {1'b0, item.now_time};
    rd_owner = valid[cur_b] ? ram_rdata[RAM_W-1:EXP_W] : 32'd0;
    rd_exp   = ram_rdata[EXP_W-1:0];
    if (state == B_DIFF) begin
      if (!valid[chosen]) begin
        rd_exp = '0;
      end
    end else if (!valid[cur_b]) begin
      rd_exp = '0;
    end
    hit     = valid[cur_b] && (rd_owner == item.flow_tag);
    spare_n = spare;
    if ((spare == AW'(NBKT)) && (rd_exp <= now_x)) begin
      spare_n = cur_b;
    end
    ram_raddr = (state == B_PRD) ? AW'(hash[BUCKET_ID_BITS-1:0]) : chosen;
    ram_we    = (state == B_M0);
    ram_wdata = {item.flow_tag, now_x + {8'd0, delta}};
    case (state)
      B_M1: begin
        mul_a = item.queue_delay_ns;
        mul_b = delta[39:20];
      end
      B_M2: begin
        mul_a = cfg.critical_delay_ns;
        mul_b = cfg.critical_score[19:0];
      end
      B_M3: begin
        mul_a = cfg.critical_delay_ns;
        mul_b = cfg.critical_score[39:20];
      end
      default: begin
        mul_a = item.queue_delay_ns;
        mul_b = delta[19:0];
      end
    endcase
    mul_p    = {20'd0, mul_a} * {32'd0, mul_b};
    load_out = (state == B_OUT) && (!m_tvalid || m_tready);
    att      = (32'(cfg.attempts) > MAX_ATTEMPTS) ? N_W'(MAX_ATTEMPTS) : N_W'(cfg.attempts);
  end

  assign q_pop = (state == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      valid    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == B_M0) begin
        valid[chosen] <= 1'b1;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            if (!cfg.protect_on) begin
              state <= B_OUT;
            end else if (att == '0) begin
              state <= B_FRD;
            end else begin
              state <= B_PRD;
            end
          end
        end
        B_PRD:  state <= B_PCMP;
        B_PCMP: begin
          if (hit || (j + N_W'(1) == n)) begin
            state <= B_FRD;
          end else begin
            state <= B_PRD;
          end
        end
        B_FRD:  state <= B_DIFF;
        B_DIFF: state <= B_SUM;
        B_SUM:  state <= B_CAP;
        B_CAP:  state <= B_M0;
        B_M0:   state <= B_M1;
        B_M1:   state <= B_M2;
        B_M2:   state <= B_M3;
        B_M3:   state <= B_CB1;
        B_CB1:  state <= B_CB2;
        B_CB2:  state <= B_CMP;
        B_CMP:  state <= B_OUT;
        B_OUT: begin
          if (load_out) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        item   <= q_item;
        score  <= q_score;
        hash   <= q_item.flow_hash;
        n      <= att;
        j      <= '0;
        spare  <= AW'(NBKT);
        chosen <= AW'(NBKT);
        off    <= !cfg.protect_on;
      end
      B_PRD: begin
        cur_b <= AW'(hash[BUCKET_ID_BITS-1:0]);
      end
      B_PCMP: begin
        spare <= spare_n;
        hash  <= hash >> BUCKET_ID_BITS;
        j     <= j + N_W'(1);
        if (hit) begin
          chosen <= cur_b;
        end else if (j + N_W'(1) == n) begin
          chosen <= spare_n;
        end
      end
      B_DIFF: begin
        diff <= (rd_exp > now_x) ? rd_exp - now_x : '0;
      end
      B_SUM: begin
        sum <= SUM_W'(diff) + SUM_W'(score);
      end
      B_CAP: begin
        delta <= (sum > SUM_W'(cfg.max_score)) ? cfg.max_score : sum[39:0];
      end
      B_M0:  p_lo <= mul_p;
      B_M1:  p_hi <= mul_p;
      B_M2:  c_lo <= mul_p;
      B_M3:  c_hi <= mul_p;
      B_CB1: pw <= P_W'(p_lo) + {p_hi, 20'd0};
      B_CB2: cw <= P_W'(c_lo) + {c_hi, 20'd0};
      B_CMP: begin
        sanc <= (item.queue_delay_ns > cfg.critical_delay_ns) && (pw > cw);
      end
      B_OUT: begin
        if (load_out) begin
          if (off) begin
            m_tdata <= '0;
          end else begin
            m_tdata <= OUT_W'({delta, chosen, sanc});
          end
        end
      end
      default: begin
        item <= item;
      end
    endcase
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import fqp_pkg::*;

  localparam int NBKT = 1 << BUCKET_ID_BITS_DEF;
  localparam int OUT_W = ((BUCKET_ID_BITS_DEF + 42 + 7) / 8) * 8;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE = 2 * (62 - PROB_FRAC_BITS_DEF) + 20 + 2 * MAX_ATTEMPTS_DEF + 10;

  typedef struct {
    bit        sanction;
    bit [5:0]  bucket;
    bit [39:0] score;
  } decision_t;

  class protection_scoreboard;
    bit        protect_on;
    bit [31:0] crit_delay;
    bit [39:0] crit_score;
    bit [39:0] max_score;
    bit [4:0]  aging;
    bit [19:0] tres;
    bit [2:0]  attempts;
    bit        claimed [NBKT+1];
    bit [31:0] owner [NBKT+1];
    bit [47:0] expiry [NBKT+1];
    decision_t pending_q[$];
    int errors;
    int inputs;
    int outputs;
    int sanctions;
    int defaults_used;

    function new();
      protect_on = 1'b1;
      crit_delay = 32'd1000000;
      crit_score = 40'd4000000;
      max_score  = 40'd5000000000;
      aging      = 5'd19;
      tres       = 20'd1;
      attempts   = 3'd2;
      for (int i = 0; i <= NBKT; i++) begin
        claimed[i] = 1'b0;
        owner[i]   = '0;
        expiry[i]  = '0;
      end
    endfunction

    function void set_reg(reg_index_t idx, bit [39:0] v);
      case (idx)
        REG_PROTECT_ON:      protect_on = v[0];
        REG_CRITICAL_DELAY:  crit_delay = v[31:0];
        REG_CRITICAL_SCORE:  crit_score = v[39:0];
        REG_MAX_SCORE:       max_score  = v[39:0];
        REG_AGING_EXPONENT:  aging      = v[4:0];
        REG_TIME_RESOLUTION: tres       = v[19:0];
        REG_ATTEMPTS:        attempts   = v[2:0];
        default: ;
      endcase
    endfunction

    function void note_input(item_t it);
      decision_t d;
      int unsigned n;
      int unsigned lg;
      int unsigned chosen;
      int unsigned spare;
      int unsigned b;
      bit owned;
      bit [31:0] h;
      bit [63:0] num;
      bit [63:0] den;
      bit [63:0] delta;
      bit [63:0] tr;
      bit [127:0] lhs;
      bit [127:0] rhs;
      inputs++;
      d.sanction = 1'b0;
      d.bucket = '0;
      d.score = '0;
      if (!protect_on) begin
        pending_q = {pending_q, d};
        return;
      end
      n = (attempts > MAX_ATTEMPTS_DEF) ? MAX_ATTEMPTS_DEF : 32'(attempts);
      chosen = NBKT;
      spare = NBKT;
      owned = 1'b0;
      h = it.flow_hash;
      for (int j = 0; j < n; j++) begin
        b = h & (NBKT - 1);
        if (claimed[b] && owner[b] == it.flow_tag) begin
          chosen = b;
          owned = 1'b1;
          break;
        end
        if (spare == NBKT && expiry[b] <= 48'(it.now_time)) spare = b;
        h = h >> BUCKET_ID_BITS_DEF;
      end
      if (!owned) begin
        chosen = spare;
        claimed[chosen] = 1'b1;
        owner[chosen] = it.flow_tag;
      end
      if (chosen == NBKT) defaults_used++;
      if (expiry[chosen] <= 48'(it.now_time)) expiry[chosen] = 48'(it.now_time);
      lg = 32'(aging);
      if (lg < 1) lg = 1;
      if (lg > 30) lg = 30;
      tr = (tres == 0) ? 64'd1 : 64'(tres);
      num = (64'(it.mark_probability) * 64'(it.packet_size)) << (30 - lg);
      den = tr << PROB_FRAC_BITS_DEF;
      delta = 64'(expiry[chosen]) - 64'(it.now_time) + num / den;
      if (delta > 64'(max_score)) delta = 64'(max_score);
      expiry[chosen] = 48'(64'(it.now_time) + delta);
      if (it.queue_delay_ns > crit_delay) begin
        lhs = 128'(it.queue_delay_ns) * 128'(delta);
        rhs = 128'(crit_score) * 128'(crit_delay);
        d.sanction = lhs > rhs;
      end
      d.bucket = 6'(chosen);
      d.score = delta[39:0];
      pending_q = {pending_q, d};
    endfunction

    function void check(bit [OUT_W-1:0] word);
      decision_t e;
      outputs++;
      if (pending_q.size() == 0) begin
        $error("result word with no decision pending: %h", word);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (word[0] != e.sanction) begin
        $error("sanction: expected %0d actual %0d", e.sanction, word[0]);
        errors++;
      end
      if (word[6:1] != e.bucket) begin
        $error("bucket_index: expected %0d actual %0d", e.bucket, word[6:1]);
        errors++;
      end
      if (word[46:7] != e.score) begin
        $error("queuing_score: expected %0d actual %0d", e.score, word[46:7]);
        errors++;
      end
      if (word[0]) sanctions++;
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;

  protection_scoreboard sb;
  int send_idle;
  int recv_idle;
  int hold_cycles;
  bit hold_done;
  int quiet_cycles;
  bit [46:0] clock_now;
  bit [31:0] tag_pool [16];
  bit [31:0] hash_pool [16];

  flow_queue_protection_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata);
  end

  always @(posedge clk) begin
    if (!hold_done && sb.inputs >= 300) begin
      hold_done <= 1'b1;
      hold_cycles <= 600;
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("flow_queue_protection_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(reg_index_t idx, bit [39:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(item_t it);
    if (sb.inputs < 620) begin
      send_idle = 29;
      recv_idle = 50;
    end else if (sb.inputs < 1240) begin
      send_idle = 50;
      recv_idle = 29;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= it;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic bit [46:0] rand47();
    return 47'({$urandom(), $urandom()});
  endfunction

  function automatic item_t make_item();
    item_t it;
    int unsigned k;
    int unsigned r;
    k = $urandom_range(0, 15);
    r = $urandom_range(0, 99);
    it.flow_tag = tag_pool[k];
    it.flow_hash = hash_pool[k];
    it.packet_size = 16'($urandom_range(40, 1500));
    it.mark_probability = 17'($urandom_range(0, 65536));
    it.queue_delay_ns = $urandom_range(0, 4000000);
    clock_now = clock_now + 47'($urandom_range(0, 3000000));
    it.now_time = clock_now;
    if (r < 8) begin
      it.flow_tag = $urandom();
      it.flow_hash = $urandom();
      it.packet_size = 16'($urandom());
      it.mark_probability = 17'($urandom());
      it.queue_delay_ns = $urandom();
      it.now_time = rand47();
    end else if (r < 14) begin
      it.now_time = clock_now - 47'($urandom_range(0, 50000000));
    end else if (r < 20) begin
      it.flow_hash = $urandom();
    end
    return it;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_item(make_item());
    drain();
  endtask

  task automatic random_config();
    write_reg(REG_PROTECT_ON, 40'($urandom_range(0, 9) != 0));
    write_reg(REG_CRITICAL_DELAY, 40'($urandom_range(0, 3000000)));
    write_reg(REG_CRITICAL_SCORE,
              40'({$urandom_range(0, 255), $urandom()} >> $urandom_range(0, 20)));
    write_reg(REG_MAX_SCORE,
              40'({$urandom_range(0, 255), $urandom()} >> $urandom_range(0, 12)));
    write_reg(REG_AGING_EXPONENT, 40'($urandom_range(0, 31)));
    write_reg(REG_TIME_RESOLUTION, 40'($urandom_range(0, 1048575) >> $urandom_range(0, 19)));
    write_reg(REG_ATTEMPTS, 40'($urandom_range(0, 7)));
    end_writes();
  endtask

  initial begin
    item_t it;
    sb = new();
    hold_cycles = 0;
    hold_done = 1'b0;
    quiet_cycles = 0;
    send_idle = 29;
    recv_idle = 50;
    clock_now = 47'd1000;
    for (int i = 0; i < 16; i++) begin
      tag_pool[i] = $urandom();
      hash_pool[i] = $urandom();
    end
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    m_tready <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    it = '0;
    send_item(it);
    it = '1;
    send_item(it);
    it = '1;
    send_item(it);
    for (int i = 0; i < 6; i++) begin
      it.flow_tag = 32'hA5A5_0001;
      it.flow_hash = 32'hFFFF_FFE0 | i;
      it.packet_size = 16'hFFFF;
      it.mark_probability = (i == 5) ? 17'h1FFFF : 17'd65536;
      it.queue_delay_ns = (i < 3) ? 32'd2000000 : 32'hFFFF_FFFF;
      it.now_time = 47'd5000 + 47'(i) * 47'd10;
      send_item(it);
    end
    it.now_time = 47'd100;
    send_item(it);
    for (int i = 0; i < 6; i++) begin
      it.flow_tag = 32'h1000 + i;
      it.flow_hash = 32'h0000_0021;
      it.packet_size = 16'd1500;
      it.mark_probability = 17'd32768;
      it.queue_delay_ns = 32'd1000001;
      it.now_time = 47'd200;
      send_item(it);
    end
    it.now_time = 47'h7FFF_FFFF_FFFF;
    it.queue_delay_ns = 32'd1000000;
    send_item(it);
    drain();
    run_random(380);

    write_reg(REG_ATTEMPTS, 40'd4);
    write_reg(REG_AGING_EXPONENT, 40'd1);
    write_reg(REG_TIME_RESOLUTION, 40'd1000000);
    write_reg(REG_MAX_SCORE, 40'hFF_FFFF_FFFF);
    write_reg(REG_CRITICAL_SCORE, 40'd0);
    write_reg(REG_CRITICAL_DELAY, 40'd0);
    end_writes();
    run_random(200);

    write_reg(REG_ATTEMPTS, 40'd7);
    write_reg(REG_AGING_EXPONENT, 40'd0);
    write_reg(REG_TIME_RESOLUTION, 40'd0);
    write_reg(REG_MAX_SCORE, 40'd0);
    end_writes();
    run_random(150);

    write_reg(REG_ATTEMPTS, 40'd0);
    write_reg(REG_AGING_EXPONENT, 40'd31);
    write_reg(REG_TIME_RESOLUTION, 40'd1);
    write_reg(REG_MAX_SCORE, 40'd5000000000);
    write_reg(REG_CRITICAL_DELAY, 40'hFFFF_FFFF);
    write_reg(REG_CRITICAL_SCORE, 40'hFF_FFFF_FFFF);
    end_writes();
    run_random(150);

    write_reg(REG_PROTECT_ON, 40'd0);
    end_writes();
    run_random(100);

    write_reg(REG_PROTECT_ON, 40'd1);
    write_reg(REG_ATTEMPTS, 40'd3);
    write_reg(REG_AGING_EXPONENT, 40'd30);
    write_reg(REG_TIME_RESOLUTION, 40'd7);
    write_reg(REG_MAX_SCORE, 40'd100000000);
    write_reg(REG_CRITICAL_SCORE, 40'd4000000);
    write_reg(REG_CRITICAL_DELAY, 40'd1000000);
    end_writes();
    run_random(300);

    for (int p = 0; p < 3; p++) begin
      random_config();
      run_random(180);
    end

    $display("covered %0d packets over nine register settings, %0d sanctions,",
             sb.inputs, sb.sanctions);
    $display("%0d default-bucket decisions, %0d result words checked",
             sb.defaults_used, sb.outputs);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("flow_queue_protection_core regression: pass");
    end else begin
      $display("flow_queue_protection_core regression: fail");
    end
    $finish;
  end

endmodule
